/* design/gmg_pkg.sv */
// Package for the grid mesh generator: result kinds, register indexes, widths.
// No dependencies.
package gmg_pkg;
	localparam int GRID_MAX_DEF = 256;
	localparam int CNT_W = 9;
	localparam int LEN_W = 16;
	localparam int CRD_W = 8;
	localparam int DIV_W = 24; // dividend width: 8-bit index times 16-bit length or 2^16

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_TRI    = 2'd1;
	localparam logic [1:0] KIND_OUT    = 2'd2;

	localparam logic [1:0] REG_POINTS_X = 2'd0;
	localparam logic [1:0] REG_POINTS_Z = 2'd1;
	localparam logic [1:0] REG_LEN_X    = 2'd2;
	localparam logic [1:0] REG_LEN_Z    = 2'd3;

	// classified item handed from front to back
	typedef struct packed {
		logic       outside;
		logic       corner;
		logic [7:0] col;
		logic [7:0] row;
	} item_t;
endpackage

/* design/gmg_front.sv */
// Front part of the grid mesh generator: accepts points, classifies them, queues them.
// Depends on gmg_pkg.
module gmg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                col,
	input  logic [7:0]                row,
	input  logic [gmg_pkg::CNT_W-1:0] nx,
	input  logic [gmg_pkg::CNT_W-1:0] nz,
	output logic                      q_valid,
	input  logic                      q_ready,
	output gmg_pkg::item_t            q_item
);
	import gmg_pkg::*;

	item_t      buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	item_t      cls;

	always_comb begin
		cls.col = col;
		cls.row = row;
		cls.outside = ({1'b0, col} >= nx) || ({1'b0, row} >= nz);
		cls.corner = ({1'b0, col} + 9'd1 < nx) && ({1'b0, row} + 9'd1 < nz);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* design/gmg_div.sv */
// Restoring divider, one quotient bit per cycle; four lanes share the sequencer.
// Depends on gmg_pkg.
module gmg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gmg_pkg::DIV_W-1:0] num [4],
	input  logic [gmg_pkg::CNT_W-1:0] den [4],
	output logic                      done,
	output logic [gmg_pkg::DIV_W-1:0] quo [4]
);
	import gmg_pkg::*;

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DIV_W-1:0]  n_q [4];
	logic [CNT_W-1:0]  d_q [4];
	logic [CNT_W:0]    r_q [4];

	assign done = busy_q && (step_q == STEP_W'(DIV_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (done) busy_q <= 1'b0;
			step_q <= step_q + STEP_W'(1);
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		logic [CNT_W+1:0] trial;
		assign trial = {r_q[i], n_q[i][DIV_W-1]} - {2'b00, d_q[i]};
		assign quo[i] = n_q[i];
		always_ff @(posedge clk) begin
			if (start) begin
				n_q[i] <= num[i];
				d_q[i] <= den[i];
				r_q[i] <= '0;
			end else if (busy_q) begin
				if (!trial[CNT_W+1]) begin
					r_q[i] <= trial[CNT_W:0];
					n_q[i] <= {n_q[i][DIV_W-2:0], 1'b1};
				end else begin
					r_q[i] <= {r_q[i][CNT_W-1:0], n_q[i][DIV_W-1]};
					n_q[i] <= {n_q[i][DIV_W-2:0], 1'b0};
				end
			end
		end
	end
endmodule

/* design/gmg_back.sv */
// Back part: computes vertex data through the divider and issues up to seven results.
// Depends on gmg_pkg and gmg_div.
module gmg_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  gmg_pkg::item_t            q_item,
	input  logic [gmg_pkg::CNT_W-1:0] nx,
	input  logic [gmg_pkg::CNT_W-1:0] nz,
	input  logic [15:0]               len_x,
	input  logic [15:0]               len_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                kind,
	output logic signed [16:0]        pos_x,
	output logic signed [16:0]        pos_z,
	output logic [16:0]               tex_u,
	output logic [16:0]               tex_v,
	output logic [15:0]               index,
	output logic                      last
);
	import gmg_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]  st_q;
	item_t       it_q;
	logic [2:0]  seq_q;
	logic [15:0] a_q;
	logic        div_start, div_done;
	logic [DIV_W-1:0] num [4];
	logic [CNT_W-1:0] den [4];
	logic [DIV_W-1:0] quo [4];
	logic [16:0] px_r, pz_r, u_r, v_r;
	logic        out_ld;
	logic [15:0] tri_idx;
	logic        tri_last;

	assign num[0] = DIV_W'(it_q.col) * DIV_W'(len_x);
	assign num[1] = DIV_W'(it_q.row) * DIV_W'(len_z);
	assign num[2] = {it_q.col, 16'h0};
	assign num[3] = {it_q.row, 16'h0};
	assign den[0] = nx - 9'd1;
	assign den[1] = nz - 9'd1;
	assign den[2] = nx - 9'd1;
	assign den[3] = nz - 9'd1;
	assign div_start = (st_q == ST_MUL);

	gmg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num), .den(den),
		.done(div_done), .quo(quo)
	);

	always_comb begin
		px_r = 17'(quo[0]) - 17'(len_x[15:1]);
		pz_r = 17'(len_z[15:1]) - 17'(quo[1]);
		u_r  = quo[2][16:0];
		v_r  = quo[3][16:0];
		case (seq_q)
			3'd0: tri_idx = a_q;
			3'd1: tri_idx = a_q + 16'd1;
			3'd2: tri_idx = a_q + 16'(nx);
			3'd3: tri_idx = a_q + 16'(nx);
			3'd4: tri_idx = a_q + 16'd1;
			default: tri_idx = a_q + 16'(nx) + 16'd1;
		endcase
		tri_last = (seq_q == 3'd5);
	end

	// output register frees when empty or being taken
	assign out_ld = !out_valid || out_ready;
	assign q_ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			seq_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (st_q == ST_EMIT && out_ld) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid) st_q <= ST_MUL;
				end
				ST_MUL: st_q <= it_q.outside ? ST_EMIT : ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_EMIT;
						seq_q <= 3'd7;
					end
				end
				ST_EMIT: begin
					if (out_ld) begin
						if (it_q.outside || (seq_q == 3'd7 && !it_q.corner) || tri_last) begin
							st_q <= ST_IDLE;
						end
						seq_q <= seq_q + 3'd1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) begin
			it_q <= q_item;
		end
		if (st_q == ST_MUL) begin
			a_q <= 16'(16'(it_q.row) * 16'(nx) + 16'(it_q.col));
		end
		if (st_q == ST_EMIT && out_ld) begin
			if (it_q.outside) begin
				kind <= KIND_OUT;
				{pos_x, pos_z, tex_u, tex_v} <= '0;
				index <= '0;
				last <= 1'b1;
			end else if (seq_q == 3'd7) begin
				kind <= KIND_VERTEX;
				pos_x <= px_r;
				pos_z <= pz_r;
				tex_u <= u_r;
				tex_v <= v_r;
				index <= a_q;
				last <= !it_q.corner;
			end else begin
				kind <= KIND_TRI;
				{pos_x, pos_z, tex_u, tex_v} <= '0;
				index <= tri_idx;
				last <= tri_last;
			end
		end
	end
endmodule

/* design/grid_mesh_generator.sv */
// Top level of the grid mesh generator: config registers, front queue, back unit.
// Depends on gmg_pkg, gmg_front, gmg_back.
//
//  channel  | handshake             | payload
//  in       | in_valid / in_ready   | col, row
//  out      | out_valid / out_ready | kind, pos_x, pos_z, tex_u, tex_v, index, last
//  cfg      | cfg_we                | cfg_idx, cfg_data
//
// The back end takes a point when idle, starts the divider in its multiply state, then
// runs 24 divider steps for x, z, u, v before the vertex is loaded.
// A cell corner then issues the vertex and six indices, one per cycle while the output is
// taken; other inside points give only the vertex; outside points skip the divider.
// A two-entry queue lets points be taken while the back end divides or stalls.
// Reset clears control state and loads the register defaults.
module grid_mesh_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         col,
	input  logic [7:0]         row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [15:0]        index,
	output logic               last,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_data
);
	import gmg_pkg::*;

	logic [8:0]  pnx_q, pnz_q;
	logic [15:0] lx_q, lz_q;
	logic [8:0]  nx, nz;
	logic        qv, qr;
	item_t       qi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnx_q <= 9'd2;
			pnz_q <= 9'd2;
			lx_q <= 16'd256;
			lz_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POINTS_X: pnx_q <= cfg_data[8:0];
				REG_POINTS_Z: pnz_q <= cfg_data[8:0];
				REG_LEN_X:    lx_q <= cfg_data;
				REG_LEN_Z:    lz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp counts to [2, GRID_MAX_DEF]
	always_comb begin
		nx = (pnx_q < 9'd2) ? 9'd2 : ((pnx_q > 9'(GRID_MAX_DEF)) ? 9'(GRID_MAX_DEF) : pnx_q);
		nz = (pnz_q < 9'd2) ? 9'd2 : ((pnz_q > 9'(GRID_MAX_DEF)) ? 9'(GRID_MAX_DEF) : pnz_q);
	end

	gmg_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.col(col), .row(row), .nx(nx), .nz(nz),
		.q_valid(qv), .q_ready(qr), .q_item(qi)
	);

	gmg_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_ready(qr), .q_item(qi),
		.nx(nx), .nz(nz), .len_x(lx_q), .len_z(lz_q),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.pos_x(pos_x), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
		.index(index), .last(last)
	);

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_VERTEX || kind == KIND_TRI || kind == KIND_OUT))
		else $error("bad kind");
	a_out_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_OUT) |-> last)
		else $error("outside point without last");
	a_tri_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_TRI) |-> (tex_u == 17'd0 && pos_x == 17'sd0))
		else $error("triangle result carries vertex data");
endmodule
